/* src/map_composition_segment_tree_top_defines.svh */
// Assertion macros for the map composition tree.
`ifndef MAP_COMPOSITION_SEGMENT_TREE_TOP_DEFINES_SVH
`define MAP_COMPOSITION_SEGMENT_TREE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MCT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication checked on every clock edge outside reset.
`define MCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

/* src/mct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mct_pkg;
   localparam int unsigned FieldCount = 8;
   localparam int unsigned FieldWidth = 3;
   localparam int unsigned IndexWidth = 10;

   typedef logic [FieldWidth-1:0] field_type;
   typedef field_type [FieldCount-1:0] image_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic clear;
   } cell_ctl_type;
endpackage
`default_nettype wire

/* src/mct_level.sv */
`timescale 1ns / 1ps
`default_nettype none
module mct_level #(
   parameter int unsigned DEPTH  = 2,
   parameter int unsigned SYMBOLS = 8,
   parameter int unsigned SYM_W  = 3,
   parameter int unsigned ADDR_W = 1
) (
   input  wire logic                         clock,
   input  wire mct_pkg::cell_ctl_type        ctl,
   input  wire logic [ADDR_W-1:0]            clr_addr,
   input  wire logic                         up_valid,
   input  wire logic [ADDR_W-1:0]            up_addr,
   input  wire logic [SYMBOLS*SYM_W-1:0]     up_map,
   output logic                              dn_valid,
   output logic [SYMBOLS*SYM_W-1:0]          dn_map
);
   import mct_pkg::*;

   logic [SYMBOLS*SYM_W-1:0] mem [DEPTH];
   logic [SYMBOLS*SYM_W-1:0] rd_ff;
   logic                     side_ff;
   logic                     valid_ff;
   logic [SYMBOLS*SYM_W-1:0] own_ff;
   logic [SYMBOLS*SYM_W-1:0] sib_map;
   logic [SYMBOLS*SYM_W-1:0] left_map;
   logic [SYMBOLS*SYM_W-1:0] right_map;
   logic [SYMBOLS*SYM_W-1:0] ident;
   logic [ADDR_W-1:0]        sib_addr;

   always_comb begin
      for (int s = 0; s < SYMBOLS; s++) begin
         ident[s*SYM_W +: SYM_W] = SYM_W'(s);
      end
   end

   assign sib_addr = up_addr ^ ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         mem[clr_addr] <= ident;
      end else if (up_valid) begin
         mem[up_addr]  <= up_map;
      end
      rd_ff         <= mem[sib_addr];
      side_ff       <= up_addr[0];
      own_ff        <= up_map;
      valid_ff      <= up_valid && !ctl.clear;
   end

   assign sib_map   = rd_ff;
   assign left_map  = side_ff ? sib_map : own_ff;
   assign right_map = side_ff ? own_ff : sib_map;

   always_comb begin
      for (int s = 0; s < SYMBOLS; s++) begin
         dn_map[s*SYM_W +: SYM_W] =
            left_map[right_map[s*SYM_W +: SYM_W]*SYM_W +: SYM_W];
      end
   end

   assign dn_valid = valid_ff;
endmodule
`default_nettype wire

/* src/map_composition_segment_tree_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Map composition tree: holds one map on SYMBOLS symbols per leaf and the
// composition of all leaves, leaf 0 applied last.
// Input channel req_*: func, leaf_index and the eight leaf images. Func 1
// reports the root map on rsp_total_*; func 0 reports nothing.
// A leaf_index of LEAVES or more writes nothing.
// The path to the root runs through a row of level cells, one per tree
// level. Each cell stores the maps of its level in a memory, writes the
// new node, reads the sibling and composes them for the cell above.
// A transfer moves one level per cycle. Items are taken one at a time:
// the next request is taken once the walk ends after a func 0 item and
// once the result is delivered after a func 1 item.
// After reset the cells write identity into every node, one node per
// cycle, and req_stall is held high meanwhile.
// A stalled result holds in the output register until taken; the next
// item is accepted once it is delivered.
module map_composition_segment_tree_top #(
   parameter int unsigned LEAVES  = 1024,
   parameter int unsigned SYMBOLS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_func,
   input  wire logic [9:0]           req_leaf_index,
   input  wire mct_pkg::field_type   req_image_0,
   input  wire mct_pkg::field_type   req_image_1,
   input  wire mct_pkg::field_type   req_image_2,
   input  wire mct_pkg::field_type   req_image_3,
   input  wire mct_pkg::field_type   req_image_4,
   input  wire mct_pkg::field_type   req_image_5,
   input  wire mct_pkg::field_type   req_image_6,
   input  wire mct_pkg::field_type   req_image_7,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output mct_pkg::field_type        rsp_total_0,
   output mct_pkg::field_type        rsp_total_1,
   output mct_pkg::field_type        rsp_total_2,
   output mct_pkg::field_type        rsp_total_3,
   output mct_pkg::field_type        rsp_total_4,
   output mct_pkg::field_type        rsp_total_5,
   output mct_pkg::field_type        rsp_total_6,
   output mct_pkg::field_type        rsp_total_7
);
   import mct_pkg::*;

   localparam int unsigned Levels = (LEAVES > 1) ? $clog2(LEAVES) : 1;
   localparam int unsigned SymW   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int unsigned MapW   = SYMBOLS * SymW;
   localparam int unsigned LeafW  = Levels;

   state_type          state_ff, state_in;
   logic               func_ff;
   logic               clear_ff;
   logic [LeafW-1:0]   clear_cnt_ff;
   logic [MapW-1:0]    total_ff;
   logic               done;
   logic [MapW-1:0]    root_map;
   logic [MapW-1:0]    leaf_map;
   logic               leaf_ok;
   logic [Levels:0]    v_chain;
   logic [MapW-1:0]    m_chain [Levels+1];
   logic [LeafW-1:0]   addr_ff;
   logic               accept;
   image_type          img;
   cell_ctl_type       ctl;
   logic [LeafW-1:0]   leaf_sel;
   logic               first_v;
   logic [MapW-1:0]    first_m;

   assign img = {req_image_7, req_image_6, req_image_5, req_image_4,
                 req_image_3, req_image_2, req_image_1, req_image_0};
   assign leaf_sel = req_leaf_index[LeafW-1:0];
   assign leaf_ok  = (32'(req_leaf_index) < LEAVES)
                  && ((LeafW >= 10) || (req_leaf_index >> LeafW) == '0);

   always_comb begin
      for (int s = 0; s < SYMBOLS; s++) begin
         if (s < FieldCount) begin
            leaf_map[s*SymW +: SymW] = (32'(img[s]) >= SYMBOLS)
               ? SymW'(SYMBOLS - 1) : SymW'(img[s]);
         end else begin
            leaf_map[s*SymW +: SymW] = SymW'(s);
         end
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || clear_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_WALK;
         ST_WALK: if (done) state_in = func_ff ? ST_SEND : ST_IDLE;
         ST_SEND: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   logic [Levels:0] walk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
         walk_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (clear_ff) begin
            clear_cnt_ff <= clear_cnt_ff + LeafW'(1);
            if (&clear_cnt_ff) begin
               clear_ff <= 1'b0;
            end
         end
         walk_ff  <= {walk_ff[Levels-1:0], accept};
      end
      if (accept) begin
         func_ff <= req_func;
         addr_ff <= leaf_sel;
      end
      if (done) begin
         total_ff <= root_map;
      end
   end

   assign done = walk_ff[Levels];

   assign ctl.clear = clear_ff;

   always_ff @(posedge clock) begin
      first_v <= accept && leaf_ok;
      first_m <= leaf_map;
   end

   assign v_chain[0] = first_v;
   assign m_chain[0] = first_m;

   genvar g;
   generate
      for (g = 0; g < Levels; g++) begin : g_lvl
         localparam int unsigned Aw = Levels - g;
         mct_level #(
            .DEPTH  (1 << Aw),
            .SYMBOLS(SYMBOLS),
            .SYM_W  (SymW),
            .ADDR_W (Aw)
         ) u_level (
            .clock   (clock),
            .ctl     (ctl),
            .clr_addr(clear_cnt_ff[Aw-1:0]),
            .up_valid(v_chain[g]),
            .up_addr (addr_ff[Levels-1:g]),
            .up_map  (m_chain[g]),
            .dn_valid(v_chain[g+1]),
            .dn_map  (m_chain[g+1])
         );
      end
   endgenerate

   logic [MapW-1:0] root_ff;
   logic            root_seen_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         root_seen_ff <= 1'b0;
      end else if (v_chain[Levels]) begin
         root_seen_ff <= 1'b1;
      end
      if (v_chain[Levels]) begin
         root_ff <= m_chain[Levels];
      end
   end

   always_comb begin
      for (int s = 0; s < SYMBOLS; s++) begin
         root_map[s*SymW +: SymW] = v_chain[Levels] ? m_chain[Levels][s*SymW +: SymW]
            : (root_seen_ff ? root_ff[s*SymW +: SymW] : SymW'(s));
      end
   end

   function automatic field_type total_of(input logic [MapW-1:0] m, input int j);
      field_type r;
      r = field_type'(j);
      if (j < SYMBOLS) begin
         r = field_type'(m[j*SymW +: SymW]);
      end
      return r;
   endfunction

   always_comb begin
      rsp_valid   = (state_ff == ST_SEND);
      rsp_total_0 = total_of(total_ff, 0);
      rsp_total_1 = total_of(total_ff, 1);
      rsp_total_2 = total_of(total_ff, 2);
      rsp_total_3 = total_of(total_ff, 3);
      rsp_total_4 = total_of(total_ff, 4);
      rsp_total_5 = total_of(total_ff, 5);
      rsp_total_6 = total_of(total_ff, 6);
      rsp_total_7 = total_of(total_ff, 7);
   end
endmodule
`default_nettype wire

/* src/mct_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "map_composition_segment_tree_top_defines.svh"
module mct_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic [2:0] rsp_total_0
);
   `MCT_ASSERT_IMPL(a_one_side, clock, reset, rsp_valid, req_stall)
   `MCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `MCT_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   `MCT_ASSERT_NEXT(a_data_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_total_0))
endmodule
bind map_composition_segment_tree_top mct_checker u_mct_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_total_0(rsp_total_0)
);
`default_nettype wire
